### sv/vag_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vag_pkg
// Shared types and constants for the volume axis gradient / adjoint block.
// -----------------------------------------------------------------------------
package vag_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_DIM_X       = 3'd0;
   localparam logic [2:0] REG_DIM_Y       = 3'd1;
   localparam logic [2:0] REG_DIM_Z       = 3'd2;
   localparam logic [2:0] REG_AXIS_SEL    = 3'd3;
   localparam logic [2:0] REG_ADJOINT     = 3'd4;
   localparam logic [2:0] REG_RECIP_SCALE = 3'd5;

   // axis select codes (unused code acts as x)
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // entries of the queue between front and back
   localparam int QDEPTH = 4;
   localparam int QC_W   = $clog2(QDEPTH + 1);

   // how the back end forms the difference
   typedef enum logic [2:0] {
      KIND_ZERO,
      KIND_NEG_CUR,
      KIND_PREV,
      KIND_PREV_MINUS_CUR,
      KIND_CUR_MINUS_PREV
   } vag_kind_type;

   typedef struct packed {
      vag_kind_type       kind;
      logic signed [15:0] cur;
      logic signed [15:0] prev;
      logic               eov_fixed;  // end flag known at the front
      logic               use_lin;    // end flag from raster index compare
   } vag_item_type;

endpackage
`default_nettype wire

### sv/vag_front.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vag_front
// Config registers, raster position, delay store and per-beat classification.
// -----------------------------------------------------------------------------
module vag_front import vag_pkg::*; #(
   parameter int MAX_DIM_X = 256,
   parameter int MAX_DIM_Y = 256,
   parameter int MAX_DIM_Z = 256,
   localparam int DEPTH  = MAX_DIM_X * MAX_DIM_Y,
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int PEND_W = $clog2(DEPTH + 1),
   localparam int PX_W   = $clog2(MAX_DIM_X),
   localparam int PY_W   = $clog2(MAX_DIM_Y),
   localparam int PZ_W   = $clog2(MAX_DIM_Z),
   localparam int DX_W   = $clog2(MAX_DIM_X + 1),
   localparam int DY_W   = $clog2(MAX_DIM_Y + 1),
   localparam int DZ_W   = $clog2(MAX_DIM_Z + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_action,
   input  wire logic signed [15:0] req_voxel_value,
   input  wire logic [QC_W-1:0]    q_count,
   output logic                    q_push,
   output vag_item_type            q_item,
   output logic [PX_W-1:0]         q_px,
   output logic [PY_W-1:0]         q_py,
   output logic [PZ_W-1:0]         q_pz,
   output logic [DX_W-1:0]         dx,
   output logic [DY_W-1:0]         dy,
   output logic [ADDR_W-1:0]       stride_m1,
   output logic [31:0]             recip
);

   logic [8:0]  csr_dim_x_ff, csr_dim_y_ff, csr_dim_z_ff;
   logic [1:0]  csr_axis_ff;
   logic        csr_adj_ff;
   logic [31:0] csr_recip_ff;
   logic        settle_ff;

   logic [DX_W-1:0]   dx_in, dx_ff;
   logic [DY_W-1:0]   dy_in, dy_ff;
   logic [DZ_W-1:0]   dz_in, dz_ff;
   logic [PEND_W-1:0] stride_in, stride_ff;
   logic [ADDR_W-1:0] stride_m1_ff;

   logic [PX_W-1:0]   pos_x_ff, pos_x_in;
   logic [PY_W-1:0]   pos_y_ff, pos_y_in;
   logic [PZ_W-1:0]   pos_z_ff, pos_z_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [ADDR_W-1:0] sp_ff, sp_in, rd_addr;

   logic signed [15:0] store_mem [DEPTH];
   logic signed [15:0] rdata_ff;

   logic         s1_valid_ff;
   vag_kind_type s1_kind_ff;
   logic signed [15:0] s1_cur_ff;
   logic         s1_eov_ff, s1_lin_ff;
   logic [PX_W-1:0] s1_px_ff;
   logic [PY_W-1:0] s1_py_ff;
   logic [PZ_W-1:0] s1_pz_ff;

   logic accept, voxel_wr, produced;
   logic last_x, last_y, last_z, coord_first, coord_last;
   vag_kind_type kind;
   logic eov_fixed, use_lin;
   logic [PEND_W:0] rd_wide;

   assign csr_ready = 1'b1;
   assign req_ready = !settle_ff && ((q_count + QC_W'(s1_valid_ff)) < QC_W'(QDEPTH));
   assign accept    = req_valid && req_ready;
   assign voxel_wr  = accept && !req_action;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_dim_x_ff <= 9'd256;
         csr_dim_y_ff <= 9'd256;
         csr_dim_z_ff <= 9'd256;
         csr_axis_ff  <= 2'd0;
         csr_adj_ff   <= 1'b0;
         csr_recip_ff <= 32'd65536;
         settle_ff    <= 1'b0;
      end else begin
         settle_ff <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_DIM_X:       csr_dim_x_ff <= csr_data[8:0];
               REG_DIM_Y:       csr_dim_y_ff <= csr_data[8:0];
               REG_DIM_Z:       csr_dim_z_ff <= csr_data[8:0];
               REG_AXIS_SEL:    csr_axis_ff  <= csr_data[1:0];
               REG_ADJOINT:     csr_adj_ff   <= csr_data[0];
               REG_RECIP_SCALE: csr_recip_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // clamp extents to [2, MAX]; derived values are registered from the config registers
   always_comb begin
      if (csr_dim_x_ff < 9'd2)                 dx_in = DX_W'(2);
      else if (32'(csr_dim_x_ff) > MAX_DIM_X)  dx_in = DX_W'(MAX_DIM_X);
      else                                     dx_in = DX_W'(csr_dim_x_ff);
      if (csr_dim_y_ff < 9'd2)                 dy_in = DY_W'(2);
      else if (32'(csr_dim_y_ff) > MAX_DIM_Y)  dy_in = DY_W'(MAX_DIM_Y);
      else                                     dy_in = DY_W'(csr_dim_y_ff);
      if (csr_dim_z_ff < 9'd2)                 dz_in = DZ_W'(2);
      else if (32'(csr_dim_z_ff) > MAX_DIM_Z)  dz_in = DZ_W'(MAX_DIM_Z);
      else                                     dz_in = DZ_W'(csr_dim_z_ff);
      unique case (csr_axis_ff)
         AXIS_Y:  stride_in = PEND_W'(dx_in);
         AXIS_Z:  stride_in = PEND_W'(dx_in) * PEND_W'(dy_in);
         default: stride_in = PEND_W'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      dz_ff        <= dz_in;
      stride_ff    <= stride_in;
      stride_m1_ff <= ADDR_W'(stride_in - PEND_W'(1));
   end

   assign dx        = dx_ff;
   assign dy        = dy_ff;
   assign stride_m1 = stride_m1_ff;
   assign recip     = csr_recip_ff;

   // ---------------- classification ----------------
   always_comb begin
      last_x = (32'(pos_x_ff) + 32'd1) >= 32'(dx_ff);
      last_y = (32'(pos_y_ff) + 32'd1) >= 32'(dy_ff);
      last_z = (32'(pos_z_ff) + 32'd1) >= 32'(dz_ff);
      unique case (csr_axis_ff)
         AXIS_Y: begin
            coord_first = (pos_y_ff == '0);
            coord_last  = last_y;
         end
         AXIS_Z: begin
            coord_first = (pos_z_ff == '0);
            coord_last  = last_z;
         end
         default: begin
            coord_first = (pos_x_ff == '0);
            coord_last  = last_x;
         end
      endcase

      produced  = 1'b0;
      kind      = KIND_ZERO;
      eov_fixed = 1'b0;
      use_lin   = 1'b0;
      pend_in   = pend_ff;
      priority if (req_action) begin
         if (pend_ff != '0 && pos_x_ff == '0 && pos_y_ff == '0 && pos_z_ff == '0) begin
            produced  = 1'b1;
            eov_fixed = (pend_ff == PEND_W'(1));
            pend_in   = pend_ff - PEND_W'(1);
         end
      end else if (csr_adj_ff) begin
         produced  = 1'b1;
         eov_fixed = last_x && last_y && last_z;
         if (coord_first)     kind = KIND_NEG_CUR;
         else if (coord_last) kind = KIND_PREV;
         else                 kind = KIND_PREV_MINUS_CUR;
      end else if (pend_ff >= stride_ff) begin
         produced = 1'b1;
         use_lin  = 1'b1;
         kind     = coord_first ? KIND_ZERO : KIND_CUR_MINUS_PREV;
      end else begin
         pend_in = pend_ff + PEND_W'(1);
      end

      // read slot one stride back, circularly
      if (PEND_W'(sp_ff) >= stride_ff)
         rd_wide = (PEND_W+1)'(sp_ff) - (PEND_W+1)'(stride_ff);
      else
         rd_wide = (PEND_W+1)'(sp_ff) + (PEND_W+1)'(DEPTH) - (PEND_W+1)'(stride_ff);
      rd_addr = rd_wide[ADDR_W-1:0];

      sp_in    = (32'(sp_ff) == DEPTH - 1) ? '0 : sp_ff + ADDR_W'(1);
      pos_x_in = pos_x_ff + PX_W'(1);
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (last_x) begin
         pos_x_in = '0;
         if (last_y) begin
            pos_y_in = '0;
            pos_z_in = last_z ? '0 : pos_z_ff + PZ_W'(1);
         end else begin
            pos_y_in = pos_y_ff + PY_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
         pos_z_ff    <= '0;
         pend_ff     <= '0;
         sp_ff       <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && produced;
         if (accept) pend_ff <= pend_in;
         if (voxel_wr) begin
            sp_ff    <= sp_in;
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
            pos_z_ff <= pos_z_in;
         end
      end
   end

   // delay store: read-before-write, read data registered
   always_ff @(posedge clock) begin
      if (voxel_wr) begin
         rdata_ff         <= store_mem[rd_addr];
         store_mem[sp_ff] <= req_voxel_value;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= kind;
         s1_cur_ff  <= req_voxel_value;
         s1_eov_ff  <= eov_fixed;
         s1_lin_ff  <= use_lin;
         s1_px_ff   <= pos_x_ff;
         s1_py_ff   <= pos_y_ff;
         s1_pz_ff   <= pos_z_ff;
      end
   end

   assign q_push         = s1_valid_ff;
   assign q_item.kind    = s1_kind_ff;
   assign q_item.cur     = s1_cur_ff;
   assign q_item.prev    = rdata_ff;
   assign q_item.eov_fixed = s1_eov_ff;
   assign q_item.use_lin = s1_lin_ff;
   assign q_px           = s1_px_ff;
   assign q_py           = s1_py_ff;
   assign q_pz           = s1_pz_ff;

endmodule
`default_nettype wire

### sv/vag_fifo.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vag_fifo
// Short queue between the front and back ends.
// -----------------------------------------------------------------------------
module vag_fifo import vag_pkg::*; #(
   parameter int WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  pop_valid,
   output logic [WIDTH-1:0]      pop_data,
   output logic [QC_W-1:0]       count
);

   localparam int QA_W = $clog2(QDEPTH);

   logic [WIDTH-1:0] entry_ff [QDEPTH];
   logic [QA_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QC_W-1:0]  count_ff;
   logic             do_pop;

   assign do_pop    = pop && (count_ff != '0);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (32'(wr_ptr_ff) == QDEPTH - 1) ? '0 : wr_ptr_ff + QA_W'(1);
         if (do_pop) rd_ptr_ff <= (32'(rd_ptr_ff) == QDEPTH - 1) ? '0 : rd_ptr_ff + QA_W'(1);
         count_ff <= count_ff + QC_W'(push) - QC_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

### sv/vag_back.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vag_back
// Difference, Q16.16 scaling, raster index for the end flag, result register.
// -----------------------------------------------------------------------------
module vag_back import vag_pkg::*; #(
   parameter int MAX_DIM_X = 256,
   parameter int MAX_DIM_Y = 256,
   parameter int MAX_DIM_Z = 256,
   localparam int DEPTH  = MAX_DIM_X * MAX_DIM_Y,
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int PX_W   = $clog2(MAX_DIM_X),
   localparam int PY_W   = $clog2(MAX_DIM_Y),
   localparam int PZ_W   = $clog2(MAX_DIM_Z),
   localparam int DX_W   = $clog2(MAX_DIM_X + 1),
   localparam int DY_W   = $clog2(MAX_DIM_Y + 1),
   localparam int T_W    = $clog2(MAX_DIM_Y * MAX_DIM_Z),
   localparam longint VOL = longint'(MAX_DIM_X) * longint'(MAX_DIM_Y) * longint'(MAX_DIM_Z),
   localparam int LIN_W  = $clog2(VOL)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire vag_item_type      q_item,
   input  wire logic [PX_W-1:0]   q_px,
   input  wire logic [PY_W-1:0]   q_py,
   input  wire logic [PZ_W-1:0]   q_pz,
   output logic                   q_pop,
   input  wire logic [DX_W-1:0]   dx,
   input  wire logic [DY_W-1:0]   dy,
   input  wire logic [ADDR_W-1:0] stride_m1,
   input  wire logic [31:0]       recip,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic signed [48:0]     rsp_grad_value,
   output logic                   rsp_end_of_volume
);

   logic advance;
   logic signed [16:0] cur_x, prev_x, d_in;
   logic [T_W-1:0]     t_in;

   logic               b1_valid_ff;
   logic signed [16:0] b1_d_ff;
   logic [T_W-1:0]     b1_t_ff;
   logic [PX_W-1:0]    b1_px_ff;
   logic               b1_eov_ff, b1_lin_ff;

   logic               b2_valid_ff;
   logic signed [49:0] prod_in;
   logic [LIN_W-1:0]   lin_in, b2_lin_ff;
   logic signed [48:0] b2_grad_ff;
   logic               b2_eov_ff, b2_lin_sel_ff;

   logic               out_valid_ff;
   logic signed [48:0] out_grad_ff;
   logic               out_eov_ff;

   // whole pipe holds while the result register is stalled
   assign advance = !out_valid_ff || rsp_ready;
   assign q_pop   = advance && q_valid;

   always_comb begin
      cur_x  = {q_item.cur[15], q_item.cur};
      prev_x = {q_item.prev[15], q_item.prev};
      unique case (q_item.kind)
         KIND_ZERO:           d_in = '0;
         KIND_NEG_CUR:        d_in = -cur_x;
         KIND_PREV:           d_in = prev_x;
         KIND_PREV_MINUS_CUR: d_in = prev_x - cur_x;
         KIND_CUR_MINUS_PREV: d_in = cur_x - prev_x;
         default:             d_in = '0;
      endcase
      t_in    = T_W'(q_py) + T_W'(dy) * T_W'(q_pz);
      prod_in = b1_d_ff * $signed({1'b0, recip});
      lin_in  = LIN_W'(b1_px_ff) + LIN_W'(dx) * LIN_W'(b1_t_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff  <= q_valid;
         b2_valid_ff  <= b1_valid_ff;
         out_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_d_ff       <= d_in;
         b1_t_ff       <= t_in;
         b1_px_ff      <= q_px;
         b1_eov_ff     <= q_item.eov_fixed;
         b1_lin_ff     <= q_item.use_lin;
         b2_grad_ff    <= prod_in[48:0];
         b2_lin_ff     <= lin_in;
         b2_eov_ff     <= b1_eov_ff;
         b2_lin_sel_ff <= b1_lin_ff;
         out_grad_ff   <= b2_grad_ff;
         out_eov_ff    <= b2_lin_sel_ff ? (b2_lin_ff == LIN_W'(stride_m1)) : b2_eov_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_grad_value    = out_grad_ff;
   assign rsp_end_of_volume = out_eov_ff;

endmodule
`default_nettype wire

### sv/volume_axis_gradient_and_adjoint.sv
`default_nettype none
// -----------------------------------------------------------------------------
// volume_axis_gradient_and_adjoint
// Forward difference or its adjoint along one axis of a raster-order volume,
// scaled by an unsigned Q16.16 factor.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_action, req_voxel_value
//   rsp      out        rsp_valid/rsp_ready   rsp_grad_value, rsp_end_of_volume
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// One beat per cycle sustained while req_ready holds; the delay store takes one read
// and one write per voxel. A result passes the front stage, the queue and the back
// registers (forward results are released a stride later, the tail by flush beats).
// req_ready drops for one cycle after each csr write while derived values settle.
// A stalled rsp holds the back pipe; the 4-entry queue keeps the front going.
// The delay store needs no clearing pass after reset.
// -----------------------------------------------------------------------------
module volume_axis_gradient_and_adjoint import vag_pkg::*; #(
   parameter int MAX_DIM_X = 256,
   parameter int MAX_DIM_Y = 256,
   parameter int MAX_DIM_Z = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_action,
   input  wire logic signed [15:0] req_voxel_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [48:0]      rsp_grad_value,
   output logic                    rsp_end_of_volume
);

   localparam int DEPTH  = MAX_DIM_X * MAX_DIM_Y;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PX_W   = $clog2(MAX_DIM_X);
   localparam int PY_W   = $clog2(MAX_DIM_Y);
   localparam int PZ_W   = $clog2(MAX_DIM_Z);
   localparam int DX_W   = $clog2(MAX_DIM_X + 1);
   localparam int DY_W   = $clog2(MAX_DIM_Y + 1);
   localparam int QW     = $bits(vag_item_type) + PX_W + PY_W + PZ_W;

   logic              q_push, q_pop, q_valid;
   logic [QC_W-1:0]   q_count;
   vag_item_type      push_item, pop_item;
   logic [PX_W-1:0]   push_px, pop_px;
   logic [PY_W-1:0]   push_py, pop_py;
   logic [PZ_W-1:0]   push_pz, pop_pz;
   logic [QW-1:0]     push_data, pop_data;
   logic [DX_W-1:0]   dx;
   logic [DY_W-1:0]   dy;
   logic [ADDR_W-1:0] stride_m1;
   logic [31:0]       recip;

   vag_front #(
      .MAX_DIM_X(MAX_DIM_X), .MAX_DIM_Y(MAX_DIM_Y), .MAX_DIM_Z(MAX_DIM_Z)
   ) u_front (
      .clock, .reset,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .req_valid, .req_ready, .req_action, .req_voxel_value,
      .q_count, .q_push,
      .q_item(push_item), .q_px(push_px), .q_py(push_py), .q_pz(push_pz),
      .dx, .dy, .stride_m1, .recip
   );

   assign push_data = {push_item, push_px, push_py, push_pz};

   vag_fifo #(.WIDTH(QW)) u_fifo (
      .clock, .reset,
      .push(q_push), .push_data,
      .pop(q_pop), .pop_valid(q_valid), .pop_data,
      .count(q_count)
   );

   assign {pop_item, pop_px, pop_py, pop_pz} = pop_data;

   vag_back #(
      .MAX_DIM_X(MAX_DIM_X), .MAX_DIM_Y(MAX_DIM_Y), .MAX_DIM_Z(MAX_DIM_Z)
   ) u_back (
      .clock, .reset,
      .q_valid, .q_item(pop_item), .q_px(pop_px), .q_py(pop_py), .q_pz(pop_pz),
      .q_pop,
      .dx, .dy, .stride_m1, .recip,
      .rsp_valid, .rsp_ready, .rsp_grad_value, .rsp_end_of_volume
   );

   // queue credit must keep a push from landing on a full queue
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count < QC_W'(QDEPTH)))
      else $error("queue push while full");

   a_cfg_settle: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> !req_ready)
      else $error("req accepted before config settled");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (q_count == '0) |-> !q_valid)
      else $error("queue shows data while empty");

endmodule
`default_nettype wire
